>>> rtl/trc_pkg.sv
package trc_pkg;

  localparam int unsigned MaxSegsPerAckDef = 64;

  localparam logic [2:0] KindEstablished = 3'd0;
  localparam logic [2:0] KindNewAck      = 3'd1;
  localparam logic [2:0] KindDupAck      = 3'd2;
  localparam logic [2:0] KindDataSent    = 3'd3;
  localparam logic [2:0] KindTimeout     = 3'd4;

  localparam logic [1:0] TmrLeave  = 2'd0;
  localparam logic [1:0] TmrStart  = 2'd1;
  localparam logic [1:0] TmrCancel = 2'd2;
  localparam logic [1:0] TmrRsvd   = 2'd3;

  localparam logic [2:0] RegVariant = 3'd0;
  localparam logic [2:0] RegMss     = 3'd1;
  localparam logic [2:0] RegNagle   = 3'd2;
  localparam logic [2:0] RegRetries = 3'd3;
  localparam logic [2:0] RegRtoMin  = 3'd4;
  localparam logic [2:0] RegRtoMax  = 3'd5;

  localparam logic [15:0] MssRst      = 16'd536;
  localparam logic [3:0]  RetriesRst  = 4'd12;
  localparam logic [17:0] RtoMinRst   = 18'd1000;
  localparam logic [17:0] RtoMaxRst   = 18'd240000;
  localparam logic [31:0] SsthreshRst = 32'd65535;
  localparam logic [17:0] RtoRst      = 18'd3000;
  localparam logic [31:0] RttVarRst   = 32'd6000;
  localparam logic [7:0]  DupThresh   = 8'd3;

  typedef struct packed {
    logic        variant_reno;
    logic [15:0] mss;
    logic        nagle_on;
    logic [3:0]  max_retries;
    logic [17:0] rto_min;
    logic [17:0] rto_max;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] una;
    logic [31:0] smax;
    logic [31:0] wnd;
    logic [31:0] first;
    logic [7:0]  dups;
    logic [31:0] sseq;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic [17:0] timeout;
    logic [1:0]  cmd;
    logic        rexmit;
    logic        abort_c;
    logic        try_send;
    logic        fso;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_RTT_EST, ST_RTT_RTO, ST_WIN, ST_SEG_DIV,
    ST_GROW, ST_CA_START, ST_CA_DIV, ST_FIN
  } state_e;

  function automatic logic [31:0] sat32(input logic [35:0] v);
    sat32 = (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // v + (t - v)/8 with truncation toward zero
  function automatic logic [31:0] eighth_step(input logic [35:0] v, input logic [35:0] t);
    logic [35:0] d;
    if (t >= v) begin
      d = (t - v) >> 3;
      eighth_step = sat32(v + d);
    end else begin
      d = (v - t) >> 3;
      eighth_step = sat32(v - d);
    end
  endfunction

endpackage

>>> rtl/trc_if.sv
interface trc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] oldest_unacked;
  logic [31:0] highest_sent;
  logic [31:0] peer_window;
  logic [31:0] first_acked_seq;
  logic [7:0]  dup_ack_count;
  logic [31:0] sent_seq;
  logic [31:0] now_ms;

  modport source(output valid, kind, oldest_unacked, highest_sent, peer_window,
                 first_acked_seq, dup_ack_count, sent_seq, now_ms, input ready);
  modport sink(input valid, kind, oldest_unacked, highest_sent, peer_window,
               first_acked_seq, dup_ack_count, sent_seq, now_ms, output ready);
endinterface

interface trc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cwnd_bytes;
  logic [31:0] slow_start_threshold;
  logic [17:0] timeout_ms;
  logic [1:0]  timer_command;
  logic        do_retransmit;
  logic        abort_connection;
  logic        try_send;
  logic        full_segments_only;

  modport source(output valid, cwnd_bytes, slow_start_threshold, timeout_ms,
                 timer_command, do_retransmit, abort_connection, try_send,
                 full_segments_only, input ready);
  modport sink(input valid, cwnd_bytes, slow_start_threshold, timeout_ms,
               timer_command, do_retransmit, abort_connection, try_send,
               full_segments_only, output ready);
endinterface

>>> rtl/trc_div.sv
module trc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  localparam int unsigned Steps = 32;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [31:0]     rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [32:0]     shifted, trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_q, quo_q[31]};
    trial   = shifted - {1'b0, den_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = CntW'(Steps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/trc_core.sv
module trc_core #(
  parameter int unsigned MaxSegs = trc_pkg::MaxSegsPerAckDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  trc_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  trc_pkg::item_t item_i,
  input  logic          out_free_i,
  output logic          fin_o,
  output trc_pkg::res_t res_o,
  output logic          div_start_o,
  output logic [31:0]   div_num_o,
  output logic [31:0]   div_den_o,
  input  logic          div_done_i,
  input  logic [31:0]   div_quo_i
);

  localparam int unsigned SegW = $clog2(MaxSegs + 1);
  localparam logic [SegW-1:0] SegsMax = SegW'(MaxSegs);
  localparam logic [SegW-1:0] SegsOne = SegW'(1);

  trc_pkg::state_e state_q, state_d;
  trc_pkg::item_t  it_q;

  logic [31:0]     cwnd_q, ss_q, srtt_q, rttvar_q, mseq_q, mstart_q, msq_q;
  logic [17:0]     rto_q;
  logic [3:0]      retry_q;
  logic            meas_q, tmr_q;
  logic [1:0]      cmd_q;
  logic            rexmit_q, abort_q, try_q, fso_q;
  logic [SegW-1:0] segs_q;

  logic [31:0]      mss32, diff, flight, half, two_mss, ss_shrink, elapsed;
  logic             una_eq, ack_samples, reno_fast, seg_div_ok, slow_start;
  logic [35:0]      m36, s36, abs_err, rto_sum, rto_raw, grow_sum, ca_sum;
  logic [31:0]      new_srtt, new_var;
  logic [17:0]      rto_clamp, rto_dbl;
  logic [18:0]      dbl;
  logic [17:0]      mss3;
  logic [4:0]       retry_next;
  logic [SegW-1:0]  segs_div;
  logic [SegW+15:0] seg_prod;

  always_comb begin
    mss32       = {16'd0, cfg_i.mss};
    una_eq      = (it_q.una == it_q.smax);
    diff        = it_q.una - it_q.first;
    flight      = (cwnd_q < it_q.wnd) ? cwnd_q : it_q.wnd;
    half        = flight >> 1;
    two_mss     = {15'd0, cfg_i.mss, 1'b0};
    ss_shrink   = (half > two_mss) ? half : two_mss;
    ack_samples = meas_q && ((mseq_q - it_q.una) >> 31) != 32'd0;
    reno_fast   = cfg_i.variant_reno && (it_q.dups >= trc_pkg::DupThresh);
    seg_div_ok  = !diff[31] && (cfg_i.mss != 16'd0);
    slow_start  = (cwnd_q <= ss_q);
    // rtt estimator
    elapsed     = it_q.now - mstart_q;
    m36         = {1'b0, elapsed, 3'b000};
    s36         = {4'd0, srtt_q};
    abs_err     = (s36 >= m36) ? (s36 - m36) : (m36 - s36);
    new_srtt    = trc_pkg::eighth_step(s36, m36);
    new_var     = trc_pkg::eighth_step({4'd0, rttvar_q}, abs_err);
    rto_sum     = {4'd0, srtt_q} + {2'd0, rttvar_q, 2'b00};
    rto_raw     = rto_sum >> 3;
    if (rto_raw > {18'd0, cfg_i.rto_max}) begin
      rto_clamp = cfg_i.rto_max;
    end else if (rto_raw < {18'd0, cfg_i.rto_min}) begin
      rto_clamp = cfg_i.rto_min;
    end else begin
      rto_clamp = rto_raw[17:0];
    end
    dbl         = {rto_q, 1'b0};
    rto_dbl     = (dbl > {1'b0, cfg_i.rto_max}) ? cfg_i.rto_max : dbl[17:0];
    mss3        = {2'd0, cfg_i.mss} + {1'b0, cfg_i.mss, 1'b0};
    retry_next  = {1'b0, retry_q} + 5'd1;
    if (div_quo_i > 32'(MaxSegs)) begin
      segs_div = SegsMax;
    end else if (div_quo_i == 32'd0) begin
      segs_div = SegsOne;
    end else begin
      segs_div = div_quo_i[SegW-1:0];
    end
    seg_prod    = segs_q * cfg_i.mss;
    grow_sum    = {4'd0, cwnd_q} + 36'(seg_prod);
    ca_sum      = {4'd0, cwnd_q} + {4'd0, div_quo_i};
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trc_pkg::ST_IDLE:     if (in_valid_i) state_d = trc_pkg::ST_EXEC;
      trc_pkg::ST_EXEC: begin
        if (it_q.kind == trc_pkg::KindNewAck) begin
          state_d = ack_samples ? trc_pkg::ST_RTT_EST : trc_pkg::ST_WIN;
        end else begin
          state_d = trc_pkg::ST_FIN;
        end
      end
      trc_pkg::ST_RTT_EST:  state_d = trc_pkg::ST_RTT_RTO;
      trc_pkg::ST_RTT_RTO:  state_d = trc_pkg::ST_WIN;
      trc_pkg::ST_WIN: begin
        if (reno_fast) state_d = trc_pkg::ST_FIN;
        else if (seg_div_ok) state_d = trc_pkg::ST_SEG_DIV;
        else state_d = trc_pkg::ST_GROW;
      end
      trc_pkg::ST_SEG_DIV:  if (div_done_i) state_d = trc_pkg::ST_GROW;
      trc_pkg::ST_GROW:     state_d = slow_start ? trc_pkg::ST_FIN : trc_pkg::ST_CA_DIV;
      trc_pkg::ST_CA_START: state_d = trc_pkg::ST_CA_DIV;
      trc_pkg::ST_CA_DIV: begin
        if (div_done_i) begin
          state_d = (segs_q == SegsOne) ? trc_pkg::ST_FIN : trc_pkg::ST_CA_START;
        end
      end
      trc_pkg::ST_FIN:      if (out_free_i) state_d = trc_pkg::ST_IDLE;
      default:              state_d = trc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = (state_q == trc_pkg::ST_IDLE);
    fin_o       = (state_q == trc_pkg::ST_FIN) && out_free_i;
    div_start_o = ((state_q == trc_pkg::ST_WIN) && !reno_fast && seg_div_ok) ||
                  ((state_q == trc_pkg::ST_GROW) && !slow_start) ||
                  (state_q == trc_pkg::ST_CA_START);
    div_num_o   = (state_q == trc_pkg::ST_WIN) ? diff : msq_q;
    div_den_o   = (state_q == trc_pkg::ST_WIN) ? mss32 : cwnd_q;
    res_o.cwnd     = cwnd_q;
    res_o.ssthresh = ss_q;
    res_o.timeout  = rto_q;
    res_o.cmd      = cmd_q;
    res_o.rexmit   = rexmit_q;
    res_o.abort_c  = abort_q;
    res_o.try_send = try_q;
    res_o.fso      = fso_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= trc_pkg::ST_IDLE;
      cwnd_q   <= '0;
      ss_q     <= trc_pkg::SsthreshRst;
      rto_q    <= trc_pkg::RtoRst;
      retry_q  <= '0;
      srtt_q   <= '0;
      rttvar_q <= trc_pkg::RttVarRst;
      meas_q   <= 1'b0;
      mseq_q   <= '0;
      mstart_q <= '0;
      tmr_q    <= 1'b0;
      cmd_q    <= trc_pkg::TmrLeave;
      rexmit_q <= 1'b0;
      abort_q  <= 1'b0;
      try_q    <= 1'b0;
      fso_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        trc_pkg::ST_EXEC: begin
          cmd_q    <= trc_pkg::TmrLeave;
          rexmit_q <= 1'b0;
          abort_q  <= 1'b0;
          try_q    <= 1'b0;
          fso_q    <= cfg_i.nagle_on && !una_eq;
          case (it_q.kind)
            trc_pkg::KindEstablished: cwnd_q <= mss32;
            trc_pkg::KindNewAck: begin
              try_q <= 1'b1;
              if (una_eq) begin
                cmd_q <= trc_pkg::TmrCancel;
                tmr_q <= 1'b0;
              end else begin
                retry_q <= '0;
                cmd_q   <= trc_pkg::TmrStart;
                tmr_q   <= 1'b1;
              end
            end
            trc_pkg::KindDupAck: begin
              if (it_q.dups == trc_pkg::DupThresh) begin
                ss_q     <= ss_shrink;
                cwnd_q   <= cfg_i.variant_reno ? {14'd0, mss3} : mss32;
                meas_q   <= 1'b0;
                retry_q  <= '0;
                cmd_q    <= trc_pkg::TmrStart;
                tmr_q    <= 1'b1;
                rexmit_q <= 1'b1;
              end else if (it_q.dups > trc_pkg::DupThresh && cfg_i.variant_reno) begin
                cwnd_q <= trc_pkg::sat32({4'd0, cwnd_q} + {4'd0, mss32});
              end
            end
            trc_pkg::KindDataSent: begin
              if (!tmr_q) begin
                retry_q <= '0;
                cmd_q   <= trc_pkg::TmrStart;
                tmr_q   <= 1'b1;
              end
              if (!meas_q) begin
                mseq_q   <= it_q.sseq;
                mstart_q <= it_q.now;
                meas_q   <= 1'b1;
              end
            end
            trc_pkg::KindTimeout: begin
              retry_q <= retry_next[4] ? 4'hF : retry_next[3:0];
              if (retry_next > {1'b0, cfg_i.max_retries}) begin
                abort_q <= 1'b1;
                tmr_q   <= 1'b0;
              end else begin
                rto_q    <= rto_dbl;
                cmd_q    <= trc_pkg::TmrStart;
                tmr_q    <= 1'b1;
                meas_q   <= 1'b0;
                ss_q     <= ss_shrink;
                cwnd_q   <= mss32;
                rexmit_q <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        trc_pkg::ST_RTT_EST: begin
          srtt_q   <= new_srtt;
          rttvar_q <= new_var;
          meas_q   <= 1'b0;
        end
        trc_pkg::ST_RTT_RTO: rto_q <= rto_clamp;
        trc_pkg::ST_WIN: begin
          segs_q <= SegsOne;
          if (reno_fast) cwnd_q <= ss_q;
        end
        trc_pkg::ST_SEG_DIV: if (div_done_i) segs_q <= segs_div;
        trc_pkg::ST_GROW: if (slow_start) cwnd_q <= trc_pkg::sat32(grow_sum);
        trc_pkg::ST_CA_DIV: begin
          if (div_done_i) begin
            cwnd_q <= trc_pkg::sat32(ca_sum);
            segs_q <= segs_q - SegsOne;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) it_q <= item_i;
    if (state_q == trc_pkg::ST_EXEC) msq_q <= cfg_i.mss * cfg_i.mss;
  end

endmodule

>>> rtl/tcp_reno_congestion_control_top.sv
// channel  | dir | handshake      | word
// in_s     | in  | valid / ready  | event: kind, sequence numbers, window, dups, time
// out_s    | out | valid / ready  | cwnd, ssthresh, rto, timer command, flags
// cfg      | in  | cfg_we_i       | register index and data, no read-back
// a plain event passes the accept, execute and finish states; its word is registered
// into the output slot when the finish state hands it over
// a new ack adds the rtt estimate and rto steps when it samples, the window steps,
// the segment count division when it runs, and one division per acked segment in
// congestion avoidance on the one 32-step shared divider, up to 64 segments
// reset clears the window state and loads the register defaults
// one event at a time; a finished word waits in the output register while the
// next event is accepted, and the sequencer holds its result until that slot frees
module tcp_reno_congestion_control_top #(
  parameter int unsigned MaxSegsPerAck = trc_pkg::MaxSegsPerAckDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  trc_in_if.sink      in_s,
  trc_out_if.source   out_s,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [17:0] cfg_data_i
);

  trc_pkg::cfg_t  cfg_q;
  trc_pkg::item_t item;
  trc_pkg::res_t  res, res_q;
  logic           out_valid_q, out_free, fin;
  logic           div_start, div_done;
  logic [31:0]    div_num, div_den, div_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.variant_reno <= 1'b0;
      cfg_q.mss          <= trc_pkg::MssRst;
      cfg_q.nagle_on     <= 1'b1;
      cfg_q.max_retries  <= trc_pkg::RetriesRst;
      cfg_q.rto_min      <= trc_pkg::RtoMinRst;
      cfg_q.rto_max      <= trc_pkg::RtoMaxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        trc_pkg::RegVariant: cfg_q.variant_reno <= cfg_data_i[0];
        trc_pkg::RegMss:     cfg_q.mss          <= cfg_data_i[15:0];
        trc_pkg::RegNagle:   cfg_q.nagle_on     <= cfg_data_i[0];
        trc_pkg::RegRetries: cfg_q.max_retries  <= cfg_data_i[3:0];
        trc_pkg::RegRtoMin:  cfg_q.rto_min      <= cfg_data_i;
        trc_pkg::RegRtoMax:  cfg_q.rto_max      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign item.kind  = in_s.kind;
  assign item.una   = in_s.oldest_unacked;
  assign item.smax  = in_s.highest_sent;
  assign item.wnd   = in_s.peer_window;
  assign item.first = in_s.first_acked_seq;
  assign item.dups  = in_s.dup_ack_count;
  assign item.sseq  = in_s.sent_seq;
  assign item.now   = in_s.now_ms;

  assign out_free = !out_valid_q || out_s.ready;

  trc_core #(
    .MaxSegs(MaxSegsPerAck)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_s.valid),
    .in_ready_o  (in_s.ready),
    .item_i      (item),
    .out_free_i  (out_free),
    .fin_o       (fin),
    .res_o       (res),
    .div_start_o (div_start),
    .div_num_o   (div_num),
    .div_den_o   (div_den),
    .div_done_i  (div_done),
    .div_quo_i   (div_quo)
  );

  trc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) res_q <= res;
  end

  assign out_s.valid                = out_valid_q;
  assign out_s.cwnd_bytes           = res_q.cwnd;
  assign out_s.slow_start_threshold = res_q.ssthresh;
  assign out_s.timeout_ms           = res_q.timeout;
  assign out_s.timer_command        = res_q.cmd;
  assign out_s.do_retransmit        = res_q.rexmit;
  assign out_s.abort_connection     = res_q.abort_c;
  assign out_s.try_send             = res_q.try_send;
  assign out_s.full_segments_only   = res_q.fso;

endmodule

>>> rtl/trc_check.sv
module trc_check (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic [1:0] cmd,
  input logic       rexmit,
  input logic       abort_c,
  input logic       try_send
);

  a_cmd_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> cmd != trc_pkg::TmrRsvd)
    else $error("reserved timer command");

  a_abort_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && abort_c |-> cmd == trc_pkg::TmrLeave && !rexmit && !try_send)
    else $error("abort with timer or retransmit");

  a_rexmit_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && rexmit |-> cmd == trc_pkg::TmrStart && !try_send)
    else $error("retransmit without timer restart");

  a_ack_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && try_send |-> cmd == trc_pkg::TmrStart || cmd == trc_pkg::TmrCancel)
    else $error("new ack without timer action");

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

endmodule

bind tcp_reno_congestion_control_top trc_check u_trc_check (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .out_valid (out_s.valid),
  .cmd       (out_s.timer_command),
  .rexmit    (out_s.do_retransmit),
  .abort_c   (out_s.abort_connection),
  .try_send  (out_s.try_send)
);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WatchdogLimit = 60000;
  localparam int unsigned HoldOffCycles = 4000;
  localparam int unsigned SettleCycles  = 2400;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [17:0] cfg_data_i;

  trc_in_if  in_if();
  trc_out_if out_if();

  tcp_reno_congestion_control_top u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_s      (in_if),
    .out_s     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // predictor copy of the registers and the connection state
  trc_pkg::cfg_t cfg_q;
  logic [31:0] cwnd_q, ssthresh_q, srtt_q, rttvar_q, meas_seq_q, meas_start_q;
  logic [17:0] rto_q;
  logic [3:0]  retries_q;
  logic        measuring_q, timer_on_q;

  trc_pkg::res_t expected_words[$];
  int unsigned mismatches;
  bit          failed;
  int unsigned burst_left;
  bit          hold_req;
  int unsigned idle_cycles;

  // flow state used to build well-formed event sequences
  logic [31:0] flow_una, flow_max, flow_ms;
  int unsigned flow_dups;

  function automatic logic [31:0] sat_to32(logic [63:0] v);
    return (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] smooth_eighth(logic [63:0] v, logic [63:0] t);
    if (t >= v) return sat_to32(v + ((t - v) >> 3));
    return sat_to32(v - ((v - t) >> 3));
  endfunction

  task automatic halve_window(logic [31:0] wnd);
    logic [31:0] flight, half, two;
    flight = (cwnd_q < wnd) ? cwnd_q : wnd;
    half = flight >> 1;
    two = {15'd0, cfg_q.mss, 1'b0};
    ssthresh_q = (half > two) ? half : two;
  endtask

  task automatic predict_event(trc_pkg::item_t it, output trc_pkg::res_t r);
    logic [63:0] m, err, rto, dbl;
    logic [31:0] diff, segs, mss;
    logic [4:0]  nxt;
    mss = {16'd0, cfg_q.mss};
    r = '0;
    r.cmd = trc_pkg::TmrLeave;
    case (it.kind)
      trc_pkg::KindEstablished: cwnd_q = mss;
      trc_pkg::KindNewAck: begin
        if (measuring_q && ((meas_seq_q - it.una) & 32'h8000_0000) != 32'd0) begin
          m = {29'd0, (it.now - meas_start_q), 3'd0};
          err = (64'(srtt_q) >= m) ? 64'(srtt_q) - m : m - 64'(srtt_q);
          srtt_q = smooth_eighth(64'(srtt_q), m);
          rttvar_q = smooth_eighth(64'(rttvar_q), err);
          rto = (64'(srtt_q) + 64'd4 * 64'(rttvar_q)) >> 3;
          if (rto > 64'(cfg_q.rto_max)) rto = 64'(cfg_q.rto_max);
          else if (rto < 64'(cfg_q.rto_min)) rto = 64'(cfg_q.rto_min);
          rto_q = (rto > 64'h3FFFF) ? 18'h3FFFF : rto[17:0];
          measuring_q = 1'b0;
        end
        if (it.una == it.smax) begin
          r.cmd = trc_pkg::TmrCancel;
          timer_on_q = 1'b0;
        end else begin
          retries_q = '0;
          r.cmd = trc_pkg::TmrStart;
          timer_on_q = 1'b1;
        end
        if (cfg_q.variant_reno && it.dups >= trc_pkg::DupThresh) begin
          cwnd_q = ssthresh_q;
        end else begin
          diff = it.una - it.first;
          segs = 32'd1;
          if (!diff[31] && mss != 32'd0) begin
            segs = diff / mss;
            if (segs < 32'd1) segs = 32'd1;
          end
          if (segs > 32'(trc_pkg::MaxSegsPerAckDef)) segs = 32'(trc_pkg::MaxSegsPerAckDef);
          if (cwnd_q <= ssthresh_q) begin
            cwnd_q = sat_to32(64'(cwnd_q) + 64'(segs) * 64'(mss));
          end else begin
            for (int i = 0; i < int'(segs); i++)
              cwnd_q = sat_to32(64'(cwnd_q) +
                                (cwnd_q != 32'd0 ? (64'(mss) * 64'(mss)) / 64'(cwnd_q)
                                                 : 64'd0));
          end
        end
        r.try_send = 1'b1;
      end
      trc_pkg::KindDupAck: begin
        if (it.dups == trc_pkg::DupThresh) begin
          halve_window(it.wnd);
          cwnd_q = cfg_q.variant_reno ? sat_to32(64'd3 * 64'(mss)) : mss;
          measuring_q = 1'b0;
          retries_q = '0;
          r.cmd = trc_pkg::TmrStart;
          timer_on_q = 1'b1;
          r.rexmit = 1'b1;
        end else if (it.dups > trc_pkg::DupThresh && cfg_q.variant_reno) begin
          cwnd_q = sat_to32(64'(cwnd_q) + 64'(mss));
        end
      end
      trc_pkg::KindDataSent: begin
        if (!timer_on_q) begin
          retries_q = '0;
          r.cmd = trc_pkg::TmrStart;
          timer_on_q = 1'b1;
        end
        if (!measuring_q) begin
          meas_seq_q = it.sseq;
          meas_start_q = it.now;
          measuring_q = 1'b1;
        end
      end
      trc_pkg::KindTimeout: begin
        nxt = {1'b0, retries_q} + 5'd1;
        retries_q = (nxt > 5'd15) ? 4'd15 : nxt[3:0];
        if (nxt > {1'b0, cfg_q.max_retries}) begin
          r.abort_c = 1'b1;
          timer_on_q = 1'b0;
        end else begin
          dbl = 64'd2 * 64'(rto_q);
          if (dbl > 64'(cfg_q.rto_max)) dbl = 64'(cfg_q.rto_max);
          rto_q = (dbl > 64'h3FFFF) ? 18'h3FFFF : dbl[17:0];
          r.cmd = trc_pkg::TmrStart;
          timer_on_q = 1'b1;
          measuring_q = 1'b0;
          halve_window(it.wnd);
          cwnd_q = mss;
          r.rexmit = 1'b1;
        end
      end
      default: ;
    endcase
    r.cwnd = cwnd_q;
    r.ssthresh = ssthresh_q;
    r.timeout = rto_q;
    r.fso = cfg_q.nagle_on && (it.una != it.smax);
  endtask

  // receiver: checks each word and stalls on its own pattern
  int unsigned hold_cnt;
  int unsigned stall_mode;
  always @(posedge clk_i or negedge rst_ni) begin
    trc_pkg::res_t got, want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_cnt = 0;
      stall_mode = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.cwnd = out_if.cwnd_bytes;
        got.ssthresh = out_if.slow_start_threshold;
        got.timeout = out_if.timeout_ms;
        got.cmd = out_if.timer_command;
        got.rexmit = out_if.do_retransmit;
        got.abort_c = out_if.abort_connection;
        got.try_send = out_if.try_send;
        got.fso = out_if.full_segments_only;
        if (expected_words.size() == 0) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
          end
        end
      end
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = HoldOffCycles;
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else if (stall_mode == 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 3 * stall_mode) == 0) ? 1'b0 : 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("tcp_reno_congestion_control_top verification failed");
      $finish;
    end
  end

  task automatic send_event(trc_pkg::item_t it);
    trc_pkg::res_t r;
    int unsigned gap;
    logic acc;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(posedge clk_i);
    in_if.valid <= 1'b1;
    in_if.kind <= it.kind;
    in_if.oldest_unacked <= it.una;
    in_if.highest_sent <= it.smax;
    in_if.peer_window <= it.wnd;
    in_if.first_acked_seq <= it.first;
    in_if.dup_ack_count <= it.dups;
    in_if.sent_seq <= it.sseq;
    in_if.now_ms <= it.now;
    // ready is sampled mid-cycle, the word moves at the following edge
    do begin
      @(negedge clk_i);
      acc = in_if.ready;
      @(posedge clk_i);
    end while (!acc);
    predict_event(it, r);
    expected_words.push_back(r);
    if (burst_left == 0) in_if.valid <= 1'b0;
  endtask

  task automatic drain_results();
    @(posedge clk_i);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [17:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      trc_pkg::RegVariant: cfg_q.variant_reno = data[0];
      trc_pkg::RegMss:     cfg_q.mss = data[15:0];
      trc_pkg::RegNagle:   cfg_q.nagle_on = data[0];
      trc_pkg::RegRetries: cfg_q.max_retries = data[3:0];
      trc_pkg::RegRtoMin:  cfg_q.rto_min = data;
      trc_pkg::RegRtoMax:  cfg_q.rto_max = data;
      default: ;
    endcase
  endtask

  task automatic write_all(bit reno, logic [15:0] mss, bit nagle, logic [3:0] retries,
                           logic [17:0] rmin, logic [17:0] rmax);
    drain_results();
    write_reg(trc_pkg::RegVariant, {17'd0, reno});
    write_reg(trc_pkg::RegMss, {2'd0, mss});
    write_reg(trc_pkg::RegNagle, {17'd0, nagle});
    write_reg(trc_pkg::RegRetries, {14'd0, retries});
    write_reg(trc_pkg::RegRtoMin, rmin);
    write_reg(trc_pkg::RegRtoMax, rmax);
  endtask

  function automatic trc_pkg::item_t ev(logic [2:0] k, logic [31:0] una, logic [31:0] smax,
                                        logic [31:0] first, logic [7:0] dups,
                                        logic [31:0] now);
    trc_pkg::item_t it;
    it.kind = k;
    it.una = una;
    it.smax = smax;
    it.wnd = $urandom();
    it.first = first;
    it.dups = dups;
    it.sseq = smax;
    it.now = now;
    return it;
  endfunction

  function automatic trc_pkg::item_t next_flow_event();
    trc_pkg::item_t it;
    logic [255:0] raw;
    int unsigned pick, span;
    logic [31:0] mss;
    mss = (cfg_q.mss == 16'd0) ? 32'd1 : {16'd0, cfg_q.mss};
    it = '0;
    pick = $urandom_range(0, 99);
    flow_ms += $urandom_range(0, 3000);
    if (pick < 8) begin
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom()};
      it = raw[$bits(trc_pkg::item_t)-1:0];
      return it;
    end
    it.now = flow_ms;
    it.wnd = ($urandom_range(0, 3) == 0) ? $urandom() : mss * $urandom_range(1, 40);
    it.sseq = flow_max;
    if (pick < 10) begin
      it.kind = trc_pkg::KindEstablished;
    end else if (pick < 45) begin
      it.kind = trc_pkg::KindNewAck;
      it.first = flow_una;
      span = flow_max - flow_una;
      if ($urandom_range(0, 30) == 0) span = 80 * mss;
      else if (span > 8 * mss) span = $urandom_range(0, 8) * mss;
      else span = $urandom_range(0, span);
      flow_una += span;
      if ($urandom_range(0, 3) == 0) flow_una = flow_max;
      it.dups = (flow_dups > 255) ? 8'd255 : flow_dups[7:0];
      flow_dups = 0;
    end else if (pick < 65) begin
      it.kind = trc_pkg::KindDupAck;
      flow_dups++;
      it.dups = (flow_dups > 255) ? 8'd255 : flow_dups[7:0];
    end else if (pick < 92) begin
      it.kind = trc_pkg::KindDataSent;
      flow_max += mss * $urandom_range(1, 4);
    end else if (pick < 98) begin
      it.kind = trc_pkg::KindTimeout;
    end else begin
      it.kind = 3'($urandom_range(5, 7));
    end
    it.una = flow_una;
    it.smax = flow_max;
    return it;
  endfunction

  task automatic test_directed();
    trc_pkg::item_t it;
    send_event(ev(trc_pkg::KindEstablished, 32'd0, 32'd0, 32'd0, 8'd0, 32'd0));
    send_event(ev(trc_pkg::KindDataSent, 32'd0, 32'd536, 32'd0, 8'd0, 32'd10));
    send_event(ev(trc_pkg::KindNewAck, 32'd536, 32'd1072, 32'd0, 8'd0, 32'd250));
    send_event(ev(trc_pkg::KindNewAck, 32'd1072, 32'd1072, 32'd536, 8'd0, 32'd300));
    send_event(ev(trc_pkg::KindNewAck, 32'd0, 32'd5000, 32'd1000, 8'd0, 32'd400));
    send_event(ev(trc_pkg::KindNewAck, 32'hFFFF_FFFF, 32'd0, 32'd0, 8'd255, 32'hFFFF_FFFF));
    send_event(ev(trc_pkg::KindDupAck, 32'd0, 32'd100, 32'd0, 8'd2, 32'd500));
    send_event(ev(trc_pkg::KindDupAck, 32'd0, 32'd100, 32'd0, 8'd3, 32'd500));
    send_event(ev(trc_pkg::KindDupAck, 32'd0, 32'd100, 32'd0, 8'd4, 32'd500));
    send_event(ev(trc_pkg::KindTimeout, 32'd0, 32'd100, 32'd0, 8'd0, 32'd900));
    for (int k = 5; k < 8; k++) send_event(ev(3'(k), 32'd1, 32'd2, 32'd0, 8'd0, 32'd0));
    // crossed clamps
    write_all(1'b1, 16'd0, 1'b0, 4'd1, 18'h3FFFF, 18'd1);
    send_event(ev(trc_pkg::KindDataSent, 32'd0, 32'd10, 32'd0, 8'd0, 32'hFFFF_FFF0));
    send_event(ev(trc_pkg::KindNewAck, 32'd10, 32'd20, 32'd0, 8'd0, 32'd100));
    send_event(ev(trc_pkg::KindDupAck, 32'd10, 32'd20, 32'd0, 8'd3, 32'd100));
    send_event(ev(trc_pkg::KindDupAck, 32'd10, 32'd20, 32'd0, 8'd7, 32'd100));
    send_event(ev(trc_pkg::KindNewAck, 32'd20, 32'd30, 32'd10, 8'd3, 32'd100));
    send_event(ev(trc_pkg::KindTimeout, 32'd20, 32'd30, 32'd0, 8'd0, 32'd100));
    send_event(ev(trc_pkg::KindTimeout, 32'd20, 32'd30, 32'd0, 8'd0, 32'd100));
    write_all(1'b0, 16'd65535, 1'b1, 4'd15, 18'h3FFFF, 18'h3FFFF);
    for (int i = 0; i < 17; i++)
      send_event(ev(trc_pkg::KindTimeout, 32'd0, 32'd1, 32'd0, 8'd0, 32'd0));
    send_event(ev(trc_pkg::KindEstablished, 32'd0, 32'd0, 32'd0, 8'd0, 32'd0));
    it = ev(trc_pkg::KindNewAck, 32'hFFFF_0000, 32'hFFFF_0001, 32'h0, 8'd0, 32'd5);
    send_event(it);
    send_event(it);
  endtask

  task automatic test_random_phase(int unsigned count);
    for (int i = 0; i < count; i++) send_event(next_flow_event());
  endtask

  task automatic test_random_configs();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_all(1'b0, 16'd536, 1'b1, 4'd12, 18'd1000, 18'd240000);
        1: write_all(1'b1, 16'd1460, 1'b0, 4'd3, 18'd1, 18'd262143);
        2: write_all(1'b1, 16'd1, 1'b1, 4'd15, 18'd200, 18'd60000);
        3: write_all(1'b0, 16'd65535, 1'b0, 4'd1, 18'd262143, 18'd1);
        default: write_all(1'($urandom()), 16'($urandom_range(1, 65535)), 1'($urandom()),
                           4'($urandom_range(1, 15)), 18'($urandom()), 18'($urandom()));
      endcase
      flow_una = $urandom();
      flow_max = flow_una;
      flow_ms = $urandom();
      flow_dups = 0;
      test_random_phase(190);
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    test_random_phase(40);
    drain_results();
    test_random_phase(30);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = trc_pkg::RegVariant;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.kind = trc_pkg::KindEstablished;
    in_if.oldest_unacked = '0;
    in_if.highest_sent = '0;
    in_if.peer_window = '0;
    in_if.first_acked_seq = '0;
    in_if.dup_ack_count = '0;
    in_if.sent_seq = '0;
    in_if.now_ms = '0;
    cfg_q = '{variant_reno: 1'b0, mss: trc_pkg::MssRst, nagle_on: 1'b1,
              max_retries: trc_pkg::RetriesRst, rto_min: trc_pkg::RtoMinRst,
              rto_max: trc_pkg::RtoMaxRst};
    cwnd_q = '0;
    ssthresh_q = trc_pkg::SsthreshRst;
    rto_q = trc_pkg::RtoRst;
    retries_q = '0;
    srtt_q = '0;
    rttvar_q = trc_pkg::RttVarRst;
    measuring_q = 1'b0;
    meas_seq_q = '0;
    meas_start_q = '0;
    timer_on_q = 1'b0;
    mismatches = 0;
    failed = 0;
    burst_left = 0;
    hold_req = 1'b0;
    idle_cycles = 0;
    flow_una = '0;
    flow_max = '0;
    flow_ms = '0;
    flow_dups = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_random_configs();
    test_backpressure();
    drain_results();

    if (!failed) begin
      $display("tcp_reno_congestion_control_top verification clean");
    end else begin
      $display("tcp_reno_congestion_control_top verification failed");
    end
    $finish;
  end

endmodule
